FILE: hdl/assert_macros.svh
// Assertion macros shared by the KEY1 cipher engine RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define KEY1_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define KEY1_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/key1_pkg.sv
// Shared types, constants and helpers of the KEY1 cipher engine.
// No dependencies; imported by every module of the block.
package key1_pkg;

   localparam int TABLE_WORDS = 1042;
   localparam int ADDR_W      = 11;

   localparam logic [ADDR_W-1:0] S1_BASE     = 11'h012;
   localparam logic [ADDR_W-1:0] S2_BASE     = 11'h112;
   localparam logic [ADDR_W-1:0] S3_BASE     = 11'h212;
   localparam logic [ADDR_W-1:0] S4_BASE     = 11'h312;
   localparam logic [ADDR_W-1:0] TABLE_END   = 11'h412;
   localparam logic [ADDR_W-1:0] REROLL_LAST = 11'h410;
   localparam logic [3:0]        LAST_ROUND  = 4'hF;
   localparam logic [4:0]        P_LAST      = 5'h11;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_INIT    = 2'd1;
   localparam logic [1:0] OP_ENCRYPT = 2'd2;
   localparam logic [1:0] OP_DECRYPT = 2'd3;

   // One write port of a table memory.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [31:0]       data;
   } key1_wr_type;

   function automatic logic [31:0] swap_bytes(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

FILE: hdl/key1_store.sv
// Base table and working key table memories, one write and one read port each.
// Depends on key1_pkg; read data is registered.
module key1_store
   import key1_pkg::*;
(
   input  logic              clock,
   input  key1_wr_type       base_wr,
   input  logic [ADDR_W-1:0] base_raddr,
   output logic [31:0]       base_rdata,
   input  key1_wr_type       key_wr,
   input  logic [ADDR_W-1:0] key_raddr,
   output logic [31:0]       key_rdata
);

   logic [31:0] base_mem [TABLE_WORDS];
   logic [31:0] key_mem  [TABLE_WORDS];

   always_ff @(posedge clock) begin
      if (base_wr.en) begin
         base_mem[base_wr.addr] <= base_wr.data;
      end
      base_rdata <= base_mem[base_raddr];
   end

   always_ff @(posedge clock) begin
      if (key_wr.en) begin
         key_mem[key_wr.addr] <= key_wr.data;
      end
      key_rdata <= key_mem[key_raddr];
   end

endmodule

FILE: hdl/key1_cipher.sv
// Iterative 16-round Feistel unit; reads P words and S-boxes from the key table.
// Depends on key1_pkg; one key table read per cycle, five reads per round.
module key1_cipher
   import key1_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              decrypt,
   input  logic [31:0]       in_lo,
   input  logic [31:0]       in_hi,
   input  logic [31:0]       key_rdata,
   output logic [ADDR_W-1:0] key_raddr,
   output logic              busy,
   output logic              done,
   output logic [31:0]       out_lo,
   output logic [31:0]       out_hi
);

   localparam logic [2:0] C_IDLE  = 3'd0;
   localparam logic [2:0] C_PWAIT = 3'd1;
   localparam logic [2:0] C_S1    = 3'd2;
   localparam logic [2:0] C_S2    = 3'd3;
   localparam logic [2:0] C_S3    = 3'd4;
   localparam logic [2:0] C_S4    = 3'd5;
   localparam logic [2:0] C_F1    = 3'd6;
   localparam logic [2:0] C_F2    = 3'd7;

   logic [2:0]  st_ff, st_in;
   logic [3:0]  rnd_ff, rnd_in;
   logic        dec_ff, dec_in;
   logic        done_ff, done_in;
   logic [31:0] a_ff, a_in, b_ff, b_in, t_ff, t_in, acc_ff, acc_in;
   logic [31:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [31:0] t_now;
   logic [4:0]  pnext;

   assign t_now = key_rdata ^ b_ff;
   // Index of the P word for the next round, counted down when decrypting.
   assign pnext = dec_ff ? (P_LAST - {1'b0, rnd_ff + 4'd1}) : {1'b0, rnd_ff + 4'd1};

   always_comb begin
      st_in   = st_ff;
      rnd_in  = rnd_ff;
      dec_in  = dec_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      t_in    = t_ff;
      acc_in  = acc_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      done_in = 1'b0;
      key_raddr = '0;
      case (st_ff)
         C_IDLE: begin
            key_raddr = decrypt ? ADDR_W'(P_LAST) : '0;
            if (start) begin
               a_in   = in_lo;
               b_in   = in_hi;
               rnd_in = '0;
               dec_in = decrypt;
               st_in  = C_PWAIT;
            end
         end
         C_PWAIT: begin
            t_in      = t_now;
            key_raddr = S1_BASE + ADDR_W'(t_now[31:24]);
            st_in     = C_S1;
         end
         C_S1: begin
            acc_in    = key_rdata;
            key_raddr = S2_BASE + ADDR_W'(t_ff[23:16]);
            st_in     = C_S2;
         end
         C_S2: begin
            acc_in    = acc_ff + key_rdata;
            key_raddr = S3_BASE + ADDR_W'(t_ff[15:8]);
            st_in     = C_S3;
         end
         C_S3: begin
            acc_in    = acc_ff ^ key_rdata;
            key_raddr = S4_BASE + ADDR_W'(t_ff[7:0]);
            st_in     = C_S4;
         end
         C_S4: begin
            b_in = (acc_ff + key_rdata) ^ a_ff;
            a_in = t_ff;
            if (rnd_ff == LAST_ROUND) begin
               key_raddr = dec_ff ? ADDR_W'(5'd1) : ADDR_W'(P_LAST - 5'd1);
               st_in     = C_F1;
            end else begin
               rnd_in    = rnd_ff + 4'd1;
               key_raddr = ADDR_W'(pnext);
               st_in     = C_PWAIT;
            end
         end
         C_F1: begin
            lo_in     = b_ff ^ key_rdata;
            key_raddr = dec_ff ? '0 : ADDR_W'(P_LAST);
            st_in     = C_F2;
         end
         C_F2: begin
            hi_in   = a_ff ^ key_rdata;
            done_in = 1'b1;
            st_in   = C_IDLE;
         end
         default: begin
            st_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= C_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      rnd_ff <= rnd_in;
      dec_ff <= dec_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      t_ff   <= t_in;
      acc_ff <= acc_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
   end

   assign busy   = (st_ff != C_IDLE);
   assign done   = done_ff;
   assign out_lo = lo_ff;
   assign out_hi = hi_ff;

endmodule

FILE: hdl/key1_blowfish_cipher_engine.sv
// KEY1 cipher engine top level: request decode, key schedule sequencer, result register.
// Depends on key1_pkg, key1_store, key1_cipher and assert_macros.svh.
//
// Usage. Requests enter on the req_ stream; req_tuser carries the opcode.
// A load request writes one word of the base table (indexes of 1042 and up
// are dropped). An init request copies the base table into the key table
// and then applies the keycode derived from the gamecode once per level;
// each application runs two block encryptions, an 18-word P update and 521
// chained encryptions. Encrypt and decrypt requests each return one result
// on the rsp_ stream once the result register is free. The rate is set by
// the single read port of the key table memory: every round needs one P
// word and four S-box words. Requests are taken one at a time; req_tready
// is high only while the sequencer is idle. A finished block waits in the
// result register while the next request is accepted; if the receiver
// stalls, a second block is held in the cipher unit until the register
// drains, and no request is taken then. Reset clears the control state and
// the keycode registers; both tables hold no defined contents until they
// are written.
`include "assert_macros.svh"

module key1_blowfish_cipher_engine
   import key1_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // fields from bit 0: table_index[10:0], table_word[42:11], gamecode[74:43],
   // level[76:75], block_low[108:77], block_high[140:109], zero fill
   input  logic [143:0] req_tdata,
   // fields from bit 0: opcode[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // fields from bit 0: out_low[31:0], out_high[63:32]
   output logic [63:0]  rsp_tdata
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_COPY  = 4'd1;
   localparam logic [3:0] ST_COPYW = 4'd2;
   localparam logic [3:0] ST_APPLY = 4'd3;
   localparam logic [3:0] ST_KCA   = 4'd4;
   localparam logic [3:0] ST_KCB   = 4'd5;
   localparam logic [3:0] ST_XORP  = 4'd6;
   localparam logic [3:0] ST_XORPW = 4'd7;
   localparam logic [3:0] ST_ROLL  = 4'd8;
   localparam logic [3:0] ST_ROLLW = 4'd9;
   localparam logic [3:0] ST_BLOCK = 4'd10;
   localparam logic [3:0] ST_WAIT  = 4'd11;

   logic [ADDR_W-1:0] f_index;
   logic [31:0]       f_word, f_game, f_low, f_high;
   logic [1:0]        f_level;

   assign f_index = req_tdata[10:0];
   assign f_word  = req_tdata[42:11];
   assign f_game  = req_tdata[74:43];
   assign f_level = req_tdata[76:75];
   assign f_low   = req_tdata[108:77];
   assign f_high  = req_tdata[140:109];

   logic [3:0]        st_ff, st_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [31:0]       kc0_ff, kc0_in, kc1_ff, kc1_in, kc2_ff, kc2_in;
   logic [1:0]        lvl_ff, lvl_in, appn_ff, appn_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [63:0]       rsp_data_ff, rsp_data_in;

   key1_wr_type       base_wr, key_wr;
   logic [ADDR_W-1:0] base_raddr, key_raddr, c_raddr;
   logic [31:0]       base_rdata, key_rdata;
   logic              c_start, c_dec, c_busy, c_done;
   logic [31:0]       c_in_lo, c_in_hi, c_lo, c_hi;
   logic              accept, slot_free;
   logic [31:0]       k1_next, k2_next;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (st_ff == ST_IDLE);
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   // The third keycode application shifts words one and two first.
   assign k1_next    = (appn_ff == 2'd2) ? (kc1_ff << 1) : kc1_ff;
   assign k2_next    = (appn_ff == 2'd2) ? (kc2_ff >> 1) : kc2_ff;

   key1_store u_store (
      .clock      (clock),
      .base_wr    (base_wr),
      .base_raddr (base_raddr),
      .base_rdata (base_rdata),
      .key_wr     (key_wr),
      .key_raddr  (key_raddr),
      .key_rdata  (key_rdata)
   );

   key1_cipher u_cipher (
      .clock     (clock),
      .reset     (reset),
      .start     (c_start),
      .decrypt   (c_dec),
      .in_lo     (c_in_lo),
      .in_hi     (c_in_hi),
      .key_rdata (key_rdata),
      .key_raddr (c_raddr),
      .busy      (c_busy),
      .done      (c_done),
      .out_lo    (c_lo),
      .out_hi    (c_hi)
   );

   always_comb begin
      st_in        = st_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      kc0_in       = kc0_ff;
      kc1_in       = kc1_ff;
      kc2_in       = kc2_ff;
      lvl_in       = lvl_ff;
      appn_in      = appn_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      base_wr      = '0;
      key_wr       = '0;
      base_raddr   = cnt_ff;
      key_raddr    = c_raddr;
      c_start      = 1'b0;
      c_dec        = 1'b0;
      c_in_lo      = '0;
      c_in_hi      = '0;
      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_tuser)
                  OP_LOAD: begin
                     base_wr.en   = (f_index < TABLE_END);
                     base_wr.addr = f_index;
                     base_wr.data = f_word;
                  end
                  OP_INIT: begin
                     kc0_in  = f_game;
                     kc1_in  = f_game >> 1;
                     kc2_in  = f_game << 1;
                     lvl_in  = f_level;
                     appn_in = '0;
                     cnt_in  = '0;
                     st_in   = ST_COPY;
                  end
                  default: begin
                     c_start = 1'b1;
                     c_dec   = (req_tuser == OP_DECRYPT);
                     c_in_lo = f_low;
                     c_in_hi = f_high;
                     st_in   = ST_BLOCK;
                  end
               endcase
            end
         end
         ST_COPY, ST_COPYW: begin
            // Base word read last cycle lands in the key table now.
            key_wr.en   = pend_ff;
            key_wr.addr = pend_addr_ff;
            key_wr.data = base_rdata;
            if (st_ff == ST_COPY) begin
               pend_in      = 1'b1;
               pend_addr_in = cnt_ff;
               cnt_in       = cnt_ff + 11'd1;
               if (cnt_ff == TABLE_END - 11'd1) begin
                  st_in = ST_COPYW;
               end
            end else begin
               st_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (appn_ff == lvl_ff) begin
               st_in = ST_IDLE;
            end else begin
               kc1_in  = k1_next;
               kc2_in  = k2_next;
               appn_in = appn_ff + 2'd1;
               c_start = 1'b1;
               c_in_lo = k1_next;
               c_in_hi = k2_next;
               st_in   = ST_KCA;
            end
         end
         ST_KCA: begin
            if (c_done) begin
               kc1_in  = c_lo;
               kc2_in  = c_hi;
               c_start = 1'b1;
               c_in_lo = kc0_ff;
               c_in_hi = c_lo;
               st_in   = ST_KCB;
            end
         end
         ST_KCB: begin
            if (c_done) begin
               kc0_in = c_lo;
               kc1_in = c_hi;
               cnt_in = '0;
               st_in  = ST_XORP;
            end
         end
         ST_XORP, ST_XORPW: begin
            key_wr.en   = pend_ff;
            key_wr.addr = pend_addr_ff;
            key_wr.data = key_rdata ^ swap_bytes(pend_addr_ff[0] ? kc1_ff : kc0_ff);
            if (st_ff == ST_XORP) begin
               key_raddr    = cnt_ff;
               pend_in      = 1'b1;
               pend_addr_in = cnt_ff;
               cnt_in       = cnt_ff + 11'd1;
               if (cnt_ff == ADDR_W'(P_LAST)) begin
                  st_in = ST_XORPW;
               end
            end else begin
               // Chain of table rewrites starts from an all-zero block.
               cnt_in  = '0;
               c_start = 1'b1;
               st_in   = ST_ROLL;
            end
         end
         ST_ROLL: begin
            if (c_done) begin
               key_wr.en   = 1'b1;
               key_wr.addr = cnt_ff;
               key_wr.data = c_hi;
               st_in       = ST_ROLLW;
            end
         end
         ST_ROLLW: begin
            key_wr.en   = 1'b1;
            key_wr.addr = cnt_ff + 11'd1;
            key_wr.data = c_lo;
            if (cnt_ff == REROLL_LAST) begin
               st_in = ST_APPLY;
            end else begin
               cnt_in  = cnt_ff + 11'd2;
               c_start = 1'b1;
               c_in_lo = c_lo;
               c_in_hi = c_hi;
               st_in   = ST_ROLL;
            end
         end
         ST_BLOCK: begin
            if (c_done) begin
               st_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {c_hi, c_lo};
               st_in        = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         kc0_ff       <= '0;
         kc1_ff       <= '0;
         kc2_ff       <= '0;
         lvl_ff       <= '0;
         appn_ff      <= '0;
      end else begin
         st_ff        <= st_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         kc0_ff       <= kc0_in;
         kc1_ff       <= kc1_in;
         kc2_ff       <= kc2_in;
         lvl_ff       <= lvl_in;
         appn_ff      <= appn_in;
      end
      cnt_ff       <= cnt_in;
      pend_addr_ff <= pend_addr_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `KEY1_ASSERT_IMP(a_key_wr_range, key_wr.en, key_wr.addr < TABLE_END, "key table write out of range")
   `KEY1_ASSERT_IMP(a_start_idle, c_start, !c_busy, "cipher started while busy")
   `KEY1_ASSERT_NEXT(a_result_loaded, (st_ff == ST_WAIT) && slot_free, rsp_tvalid, "result not loaded")

endmodule
